/* hdl/adaptive_chunk_size_controller_top_macros.svh */
// assertion macros for the adaptive chunk size controller checker
// expects clk and rst in the scope of each use
`ifndef ADAPTIVE_CHUNK_SIZE_CONTROLLER_TOP_MACROS_SVH
`define ADAPTIVE_CHUNK_SIZE_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define ACSC_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// next-cycle implication
`define ACSC_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

/* hdl/acsc_pkg.sv */
// shared types and constants for the adaptive chunk size controller
// no dependencies
`default_nettype none

package acsc_pkg;

  localparam int UNIT_W    = 10;
  localparam int COL_W     = 20;
  localparam int POS_W     = 21;
  localparam int CHUNK_W   = 24;
  localparam int TIME_W    = 16;
  localparam int DWELL_W   = 8;
  localparam int RATE_W    = 40;
  localparam int WORK_W    = 60;
  localparam int US_W      = 24;
  localparam int FRAC_W    = 16;
  localparam int DIV_W     = 36;
  localparam int DVS_W     = 24;
  localparam int DIV_CNT_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 60;

  localparam logic [UNIT_W-1:0]  PART_RESET   = 10'd16;
  localparam logic [UNIT_W-1:0]  STEP_RESET   = 10'd2;
  localparam logic [DWELL_W-1:0] DWELL_RESET  = 8'd1;
  localparam logic [CHUNK_W-1:0] MIN_RESET    = 24'd1;
  localparam logic [CHUNK_W-1:0] MAX_RESET    = 24'd0;
  localparam logic [TIME_W-1:0]  TARGET_RESET = 16'd1000;
  localparam logic [WORK_W-1:0]  THR_RESET    = 60'd0;
  localparam logic [DWELL_W-1:0] DWELL_MAX    = 8'hFF;
  localparam logic [CHUNK_W-1:0] CHUNK_MAX    = 24'hFFFFFF;
  localparam logic [FRAC_W:0]    ROUND_HALF   = 17'h08000;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_DONE   = 1'b1;
  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_UNITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DWELL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHUNK       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TIME     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WORK_THRESHOLD  = 3'd7;

  typedef struct packed {
    logic               cmd;
    logic [COL_W-1:0]   rows;
    logic [COL_W-1:0]   cols;
    logic [COL_W-1:0]   depth;
    logic [UNIT_W-1:0]  unit_target;
    logic [US_W-1:0]    elapsed_us;
  } job_t;

  typedef struct packed {
    logic               kind;
    logic [UNIT_W-1:0]  unit_count;
    logic [COL_W-1:0]   chunk_start;
    logic [COL_W-1:0]   chunk_width;
    logic               switched;
  } plan_t;

  typedef struct packed {
    logic               dynamic_enable;
    logic [UNIT_W-1:0]  unit_step;
    logic [UNIT_W-1:0]  partition_units;
    logic [DWELL_W-1:0] min_dwell;
    logic [CHUNK_W-1:0] min_chunk;
    logic [CHUNK_W-1:0] max_chunk;
    logic [TIME_W-1:0]  target_time;
    logic [WORK_W-1:0]  work_threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_ROWS_COLS,
    MUL_TIMES_DEPTH,
    MUL_RATE_TARGET
  } mul_op_t;

  typedef enum logic {
    DIV_SNAP,
    DIV_RATE
  } div_op_t;

  typedef enum logic [1:0] {
    COM_START,
    COM_IDLE_DONE,
    COM_FLAT_DONE,
    COM_CHUNK_DONE
  } com_op_t;

  typedef struct packed {
    logic    capture;
    mul_op_t mul_op;
    logic    thr_check;
    logic    div_start;
    div_op_t div_op;
    logic    rate_upd;
    logic    rnd;
    logic    clamp;
    logic    commit;
    com_op_t com_op;
  } dp_cmd_t;

  typedef struct packed {
    logic issued_zero;
    logic chunked;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/acsc_div.sv */
// restoring divider, one quotient bit per cycle
// depends on acsc_pkg
`default_nettype none

module acsc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [acsc_pkg::DIV_W-1:0]     dividend,
  input  logic [acsc_pkg::DVS_W-1:0]     divisor,
  input  logic [acsc_pkg::DIV_CNT_W-1:0] steps,
  output logic                           done,
  output logic [acsc_pkg::DIV_W-1:0]     quotient,
  output logic [acsc_pkg::DVS_W-1:0]     remainder
);

  logic [acsc_pkg::DIV_W-1:0]     quo;
  logic [acsc_pkg::DVS_W-1:0]     rem;
  logic [acsc_pkg::DVS_W-1:0]     dvs;
  logic [acsc_pkg::DIV_CNT_W-1:0] count;
  logic                           busy;
  logic [acsc_pkg::DVS_W:0]       partial;
  logic [acsc_pkg::DVS_W+1:0]     diff;
  logic                           fits;

  always_comb begin
    partial = {rem, quo[acsc_pkg::DIV_W-1]};
    diff    = {1'b0, partial} - {2'b00, dvs};
    fits    = ~diff[acsc_pkg::DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= steps;
      quo   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= fits ? diff[acsc_pkg::DVS_W-1:0] : partial[acsc_pkg::DVS_W-1:0];
      quo   <= {quo[acsc_pkg::DIV_W-2:0], fits};
      count <= count - 1'b1;
      if (count == acsc_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

/* hdl/acsc_dp.sv */
// datapath: job state, shared multiplier, divider, chunk planning and result register
// depends on acsc_pkg and acsc_div
`default_nettype none

module acsc_dp #(
  parameter int MAX_UNITS = 1023,
  parameter int COL_BITS  = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  acsc_pkg::cfg_t     cfg,
  input  acsc_pkg::job_t     job,
  input  acsc_pkg::dp_cmd_t  ctl,
  output acsc_pkg::dp_stat_t stat,
  input  logic               plan_stall,
  output logic               plan_valid,
  output acsc_pkg::plan_t    plan
);

  localparam int CW       = acsc_pkg::COL_W;
  localparam int UW       = acsc_pkg::UNIT_W;
  localparam int COL_KEEP = (COL_BITS < CW) ? COL_BITS : CW;
  localparam logic [CW-1:0] COL_MASK = CW'((64'd1 << COL_KEEP) - 64'd1);

  function automatic logic [UW-1:0] snap(input logic [UW-1:0] target,
                                         input logic [UW-1:0] rem,
                                         input logic [UW-1:0] step,
                                         input logic [UW-1:0] part);
    logic [UW-1:0] r;
    if (target == '0 || target >= part) begin
      r = part;
    end else begin
      r = target - rem;
      if (r < step) r = step;
      if (r > part) r = part;
    end
    if (32'(r) > MAX_UNITS) r = UW'(MAX_UNITS);
    return r;
  endfunction

  acsc_pkg::job_t                       item;
  logic [acsc_pkg::WORK_W-1:0]          prod;
  logic                                 chunked_flag;
  logic [UW-1:0]                        active;
  logic [acsc_pkg::POS_W-1:0]           position;
  logic [CW-1:0]                        total;
  logic [acsc_pkg::CHUNK_W-1:0]         planned;
  logic [CW-1:0]                        issued;
  logic [acsc_pkg::RATE_W-1:0]          rate;
  logic [acsc_pkg::DWELL_W-1:0]         dwell;
  logic                                 chunked;

  logic [acsc_pkg::RATE_W-1:0]          mul_a;
  logic [CW-1:0]                        mul_b;
  logic [acsc_pkg::WORK_W-1:0]          mul_res;

  logic [acsc_pkg::DIV_W-1:0]           div_dividend;
  logic [acsc_pkg::DVS_W-1:0]           div_divisor;
  logic [acsc_pkg::DIV_CNT_W-1:0]       div_steps;
  logic                                 div_done;
  logic [acsc_pkg::DIV_W-1:0]           div_quo;
  logic [acsc_pkg::DVS_W-1:0]           div_rem;

  logic [UW-1:0]                        step_eff;
  logic [acsc_pkg::US_W-1:0]            us_eff;
  logic [CW-1:0]                        cols_m;
  logic [UW-1:0]                        snap_val;
  logic [UW-1:0]                        want_start;
  logic [acsc_pkg::CHUNK_W-1:0]         planned_start;
  logic [CW-1:0]                        w_start;
  logic [acsc_pkg::POS_W-1:0]           pos_sum;
  logic                                 reached;
  logic [CW-1:0]                        left;
  logic [CW-1:0]                        w_chunk;
  logic                                 sw_chunk;
  logic [acsc_pkg::RATE_W:0]            rate_sum;
  logic [acsc_pkg::DIV_W+acsc_pkg::FRAC_W:0] rnd_sum;
  logic [acsc_pkg::DIV_W:0]             rnd_val;
  logic [acsc_pkg::CHUNK_W-1:0]         clamp_val;

  // operand select for the shared multiplier
  always_comb begin
    unique case (ctl.mul_op)
      acsc_pkg::MUL_ROWS_COLS: begin
        mul_a = acsc_pkg::RATE_W'(item.rows);
        mul_b = cols_m;
      end
      acsc_pkg::MUL_TIMES_DEPTH: begin
        mul_a = prod[acsc_pkg::RATE_W-1:0];
        mul_b = item.depth;
      end
      acsc_pkg::MUL_RATE_TARGET: begin
        mul_a = rate;
        mul_b = CW'(cfg.target_time);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  always_comb begin
    step_eff = (cfg.unit_step == '0) ? UW'(1) : cfg.unit_step;
    us_eff   = (item.elapsed_us == '0) ? acsc_pkg::US_W'(1) : item.elapsed_us;
    cols_m   = item.cols & COL_MASK;
    unique case (ctl.div_op)
      acsc_pkg::DIV_SNAP: begin
        div_dividend = {item.unit_target, (acsc_pkg::DIV_W-UW)'(0)};
        div_divisor  = acsc_pkg::DVS_W'(step_eff);
        div_steps    = acsc_pkg::DIV_CNT_W'(UW);
      end
      acsc_pkg::DIV_RATE: begin
        div_dividend = {issued, acsc_pkg::FRAC_W'(0)};
        div_divisor  = us_eff;
        div_steps    = acsc_pkg::DIV_CNT_W'(acsc_pkg::DIV_W);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
      end
    endcase
  end

  acsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .steps     (div_steps),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    snap_val = snap(item.unit_target, div_rem[UW-1:0], step_eff, cfg.partition_units);

    // start of a job
    want_start    = chunked_flag ? snap_val : cfg.partition_units;
    planned_start = (cfg.min_chunk != '0) ? cfg.min_chunk : acsc_pkg::CHUNK_W'(1);
    if (chunked_flag && planned_start < acsc_pkg::CHUNK_W'(cols_m))
      w_start = planned_start[CW-1:0];
    else
      w_start = cols_m;

    // chunk done
    pos_sum  = position + acsc_pkg::POS_W'(issued);
    reached  = position >= acsc_pkg::POS_W'(total);
    left     = total - position[CW-1:0];
    if (planned < acsc_pkg::CHUNK_W'(left))
      w_chunk = planned[CW-1:0];
    else
      w_chunk = left;
    if (w_chunk == '0) w_chunk = CW'(1);
    sw_chunk = (snap_val != active) && (dwell >= cfg.min_dwell);

    // rate average and next width
    rate_sum = acsc_pkg::RATE_W'(div_quo) + (acsc_pkg::RATE_W+1)'(rate);
    rnd_sum  = (acsc_pkg::DIV_W+acsc_pkg::FRAC_W+1)'(prod[acsc_pkg::DIV_W+acsc_pkg::FRAC_W-1:0])
             + (acsc_pkg::DIV_W+acsc_pkg::FRAC_W+1)'(acsc_pkg::ROUND_HALF);
    rnd_val  = rnd_sum[acsc_pkg::DIV_W+acsc_pkg::FRAC_W:acsc_pkg::FRAC_W];
    clamp_val = planned;
    if (clamp_val < cfg.min_chunk) clamp_val = cfg.min_chunk;
    if (cfg.max_chunk != '0 && clamp_val > cfg.max_chunk) clamp_val = cfg.max_chunk;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) item <= job;
    if (ctl.mul_op != acsc_pkg::MUL_NONE) prod <= mul_res;
    if (ctl.thr_check) chunked_flag <= cfg.dynamic_enable && (prod >= cfg.work_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= acsc_pkg::PART_RESET;
      position <= '0;
      total    <= '0;
      planned  <= acsc_pkg::CHUNK_W'(1);
      issued   <= '0;
      rate     <= '0;
      dwell    <= '0;
      chunked  <= 1'b0;
    end else begin
      if (ctl.rate_upd) begin
        rate     <= (rate == '0) ? acsc_pkg::RATE_W'(div_quo)
                                 : rate_sum[acsc_pkg::RATE_W:1];
        position <= pos_sum;
        if (dwell != acsc_pkg::DWELL_MAX) dwell <= dwell + 1'b1;
      end
      if (ctl.rnd) begin
        if (rnd_val[acsc_pkg::DIV_W:acsc_pkg::CHUNK_W] != '0)
          planned <= acsc_pkg::CHUNK_MAX;
        else
          planned <= rnd_val[acsc_pkg::CHUNK_W-1:0];
      end
      if (ctl.clamp) planned <= clamp_val;
      if (ctl.commit) begin
        unique case (ctl.com_op)
          acsc_pkg::COM_START: begin
            total    <= cols_m;
            position <= '0;
            rate     <= '0;
            planned  <= planned_start;
            dwell    <= cfg.min_dwell;
            chunked  <= chunked_flag;
            active   <= want_start;
            issued   <= (cols_m == '0) ? '0 : w_start;
          end
          acsc_pkg::COM_IDLE_DONE: begin
          end
          acsc_pkg::COM_FLAT_DONE: begin
            position <= pos_sum;
            issued   <= '0;
          end
          acsc_pkg::COM_CHUNK_DONE: begin
            if (reached) begin
              issued <= '0;
            end else begin
              issued <= w_chunk;
              if (sw_chunk) begin
                active <= snap_val;
                dwell  <= '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
    end else if (ctl.commit) begin
      plan_valid <= 1'b1;
    end else if (!plan_stall) begin
      plan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      unique case (ctl.com_op)
        acsc_pkg::COM_START: begin
          plan <= '{kind:        (cols_m == '0) ? acsc_pkg::KIND_END : acsc_pkg::KIND_CHUNK,
                    unit_count:  want_start,
                    chunk_start: '0,
                    chunk_width: (cols_m == '0) ? '0 : w_start,
                    switched:    want_start != active};
        end
        acsc_pkg::COM_IDLE_DONE: begin
          plan <= '{kind: acsc_pkg::KIND_END, unit_count: active,
                    chunk_start: position[CW-1:0], chunk_width: '0, switched: 1'b0};
        end
        acsc_pkg::COM_FLAT_DONE: begin
          plan <= '{kind: acsc_pkg::KIND_END, unit_count: active,
                    chunk_start: pos_sum[CW-1:0], chunk_width: '0, switched: 1'b0};
        end
        acsc_pkg::COM_CHUNK_DONE: begin
          if (reached)
            plan <= '{kind: acsc_pkg::KIND_END, unit_count: active,
                      chunk_start: position[CW-1:0], chunk_width: '0, switched: 1'b0};
          else
            plan <= '{kind:        acsc_pkg::KIND_CHUNK,
                      unit_count:  sw_chunk ? snap_val : active,
                      chunk_start: position[CW-1:0],
                      chunk_width: w_chunk,
                      switched:    sw_chunk};
        end
        default: begin
        end
      endcase
    end
  end

  assign stat = '{issued_zero: issued == '0,
                  chunked:     chunked,
                  div_done:    div_done,
                  out_free:    !plan_valid || !plan_stall};

endmodule

`default_nettype wire

/* hdl/acsc_ctrl.sv */
// sequencer for the chunk planner: steps the datapath through each word
// depends on acsc_pkg
`default_nettype none

module acsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  logic               job_cmd,
  output logic               job_stall,
  input  acsc_pkg::dp_stat_t stat,
  output acsc_pkg::dp_cmd_t  ctl
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_THR,
    ST_SNAP_WAIT,
    ST_DN_CHECK,
    ST_DN_DIV,
    ST_DN_MUL,
    ST_DN_RND,
    ST_DN_CLAMP,
    ST_DN_SNAP,
    ST_COMMIT
  } state_t;

  state_t             state;
  state_t             state_next;
  acsc_pkg::com_op_t  com_op;
  acsc_pkg::com_op_t  com_op_next;

  always_comb begin
    state_next    = state;
    com_op_next   = com_op;
    ctl           = '0;
    ctl.mul_op    = acsc_pkg::MUL_NONE;
    ctl.div_op    = acsc_pkg::DIV_SNAP;
    unique case (state)
      ST_IDLE: begin
        ctl.capture = job_valid;
        if (job_valid) begin
          if (job_cmd == acsc_pkg::CMD_START) begin
            state_next  = ST_MUL0;
            com_op_next = acsc_pkg::COM_START;
          end else begin
            state_next = ST_DN_CHECK;
          end
        end
      end
      ST_MUL0: begin
        ctl.mul_op    = acsc_pkg::MUL_ROWS_COLS;
        ctl.div_start = 1'b1;
        state_next    = ST_MUL1;
      end
      ST_MUL1: begin
        ctl.mul_op = acsc_pkg::MUL_TIMES_DEPTH;
        state_next = ST_THR;
      end
      ST_THR: begin
        ctl.thr_check = 1'b1;
        state_next    = ST_SNAP_WAIT;
      end
      ST_SNAP_WAIT: begin
        if (stat.div_done) state_next = ST_COMMIT;
      end
      ST_DN_CHECK: begin
        priority if (stat.issued_zero) begin
          com_op_next = acsc_pkg::COM_IDLE_DONE;
          state_next  = ST_COMMIT;
        end else if (!stat.chunked) begin
          com_op_next = acsc_pkg::COM_FLAT_DONE;
          state_next  = ST_COMMIT;
        end else begin
          com_op_next   = acsc_pkg::COM_CHUNK_DONE;
          ctl.div_start = 1'b1;
          ctl.div_op    = acsc_pkg::DIV_RATE;
          state_next    = ST_DN_DIV;
        end
      end
      ST_DN_DIV: begin
        if (stat.div_done) begin
          ctl.rate_upd = 1'b1;
          state_next   = ST_DN_MUL;
        end
      end
      ST_DN_MUL: begin
        ctl.mul_op    = acsc_pkg::MUL_RATE_TARGET;
        ctl.div_start = 1'b1;
        state_next    = ST_DN_RND;
      end
      ST_DN_RND: begin
        ctl.rnd    = 1'b1;
        state_next = ST_DN_CLAMP;
      end
      ST_DN_CLAMP: begin
        ctl.clamp  = 1'b1;
        state_next = ST_DN_SNAP;
      end
      ST_DN_SNAP: begin
        if (stat.div_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        ctl.commit = stat.out_free;
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ctl.com_op = com_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      com_op <= acsc_pkg::COM_IDLE_DONE;
    end else begin
      state  <= state_next;
      com_op <= com_op_next;
    end
  end

  assign job_stall = (state != ST_IDLE);

endmodule

`default_nettype wire

/* hdl/adaptive_chunk_size_controller_top.sv */
// top level of the adaptive chunk size controller: configuration registers,
// sequencer and datapath; depends on acsc_pkg, acsc_ctrl, acsc_dp
// One word in gives exactly one word out, and the block works on one word at a
// time while a finished result may still wait in the output register. A start
// word makes two passes through the shared 40x20 multiplier for the work size
// and runs a 10-step divide that snaps the unit count to the step grid. A
// chunk-done word for a chunked job runs the 36-step restoring divide for the
// column rate followed by the 10-step snap divide. A chunk-done word with no
// chunk outstanding or for a single-chunk job goes straight to the commit with
// no divide. Configuration writes are always ready and should be made only
// while the block is idle.
`default_nettype none

module adaptive_chunk_size_controller_top #(
  parameter int MAX_UNITS = 1023,
  parameter int COL_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  output logic                              job_stall,
  input  acsc_pkg::job_t                    job,
  output logic                              plan_valid,
  input  logic                              plan_stall,
  output acsc_pkg::plan_t                   plan,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [acsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  acsc_pkg::cfg_t     cfg;
  acsc_pkg::dp_cmd_t  ctl;
  acsc_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dynamic_enable  <= 1'b0;
      cfg.unit_step       <= acsc_pkg::STEP_RESET;
      cfg.partition_units <= acsc_pkg::PART_RESET;
      cfg.min_dwell       <= acsc_pkg::DWELL_RESET;
      cfg.min_chunk       <= acsc_pkg::MIN_RESET;
      cfg.max_chunk       <= acsc_pkg::MAX_RESET;
      cfg.target_time     <= acsc_pkg::TARGET_RESET;
      cfg.work_threshold  <= acsc_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acsc_pkg::REG_DYNAMIC_ENABLE:  cfg.dynamic_enable  <= cfg_data[0];
        acsc_pkg::REG_UNIT_STEP:       cfg.unit_step       <= cfg_data[acsc_pkg::UNIT_W-1:0];
        acsc_pkg::REG_PARTITION_UNITS: cfg.partition_units <= cfg_data[acsc_pkg::UNIT_W-1:0];
        acsc_pkg::REG_MIN_DWELL:       cfg.min_dwell       <= cfg_data[acsc_pkg::DWELL_W-1:0];
        acsc_pkg::REG_MIN_CHUNK:       cfg.min_chunk       <= cfg_data[acsc_pkg::CHUNK_W-1:0];
        acsc_pkg::REG_MAX_CHUNK:       cfg.max_chunk       <= cfg_data[acsc_pkg::CHUNK_W-1:0];
        acsc_pkg::REG_TARGET_TIME:     cfg.target_time     <= cfg_data[acsc_pkg::TIME_W-1:0];
        acsc_pkg::REG_WORK_THRESHOLD:  cfg.work_threshold  <= cfg_data[acsc_pkg::WORK_W-1:0];
      endcase
    end
  end

  acsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_cmd   (job.cmd),
    .job_stall (job_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  acsc_dp #(
    .MAX_UNITS (MAX_UNITS),
    .COL_BITS  (COL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job        (job),
    .ctl        (ctl),
    .stat       (stat),
    .plan_stall (plan_stall),
    .plan_valid (plan_valid),
    .plan       (plan)
  );

endmodule

`default_nettype wire

/* hdl/acsc_chk.sv */
// port-level checker for the adaptive chunk size controller, bound to the top level
// depends on acsc_pkg and adaptive_chunk_size_controller_top_macros.svh
`default_nettype none

`include "adaptive_chunk_size_controller_top_macros.svh"

module acsc_chk (
  input logic            clk,
  input logic            rst,
  input logic            job_valid,
  input logic            job_stall,
  input logic            plan_valid,
  input logic            plan_stall,
  input acsc_pkg::plan_t plan
);

  // a stalled result word holds
  `ACSC_ASSERT_NEXT(a_plan_hold, plan_valid && plan_stall, plan_valid && $stable(plan), "stalled plan word changed")

  // one word at a time: busy right after taking a word
  `ACSC_ASSERT_NEXT(a_busy_after_accept, job_valid && !job_stall, job_stall, "second word taken while busy")

  // a new result only comes out of work on an accepted word
  `ACSC_ASSERT_NOW(a_plan_from_work, $rose(plan_valid), $past(job_stall), "plan word without a job word")

  // chunks have width, finish words have none
  `ACSC_ASSERT_NOW(a_kind_width, plan_valid, (plan.kind == acsc_pkg::KIND_CHUNK) == (plan.chunk_width != '0), "kind and width disagree")

endmodule

bind adaptive_chunk_size_controller_top acsc_chk u_acsc_chk (
  .clk        (clk),
  .rst        (rst),
  .job_valid  (job_valid),
  .job_stall  (job_stall),
  .plan_valid (plan_valid),
  .plan_stall (plan_stall),
  .plan       (plan)
);

`default_nettype wire
